// ----- hdl/tkdb_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tkdb_pkg
// Shared types and constants for the touch key debounce and backlight block.
// -----------------------------------------------------------------------------
package tkdb_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int TOUCH_W      = 16;
	localparam int REG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	// item modes
	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_READ     = 2'd1;
	localparam logic [1:0] MODE_SET_DISP = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DISP_HOLD  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_HOLD = 2'd2;

	// reset values
	localparam logic [7:0]  DEBOUNCE_RST    = 8'd5;
	localparam logic [15:0] DISP_HOLD_RST   = 16'd2000;
	localparam logic [15:0] LIGHT_HOLD_RST  = 16'd2000;
	localparam logic [15:0] DISP_TIMER_RST  = 16'd2000;

	typedef struct packed {
		logic [1:0]         mode;
		logic [TOUCH_W-1:0] touch_vector;
		logic [15:0]        display_time;
	} in_beat_t;

	typedef struct packed {
		logic               key_valid;
		logic [3:0]         key_channel;
		logic [TOUCH_W-1:0] accepted_mask;
		logic               beep;
		logic               display_on;
		logic [TOUCH_W-1:0] key_led_mask;
		logic [15:0]        display_time_left;
	} out_beat_t;

endpackage

// ----- hdl/tkdb_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tkdb_if
// Valid/ready channels carrying input and result beats.
// -----------------------------------------------------------------------------
interface tkdb_in_if;
	logic               valid;
	logic               ready;
	tkdb_pkg::in_beat_t beat;

	modport source (output valid, output beat, input ready);
	modport sink   (input valid, input beat, output ready);
endinterface

interface tkdb_out_if;
	logic                valid;
	logic                ready;
	tkdb_pkg::out_beat_t beat;

	modport source (output valid, output beat, input ready);
	modport sink   (input valid, input beat, output ready);
endinterface

// ----- hdl/tkdb_scan.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tkdb_scan
// Per-channel press counters; flags channels reaching the debounce count.
// -----------------------------------------------------------------------------
module tkdb_scan #(
	parameter int LANES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_en,
	input  logic [LANES-1:0] touch,
	input  logic [7:0]       debounce_count,
	output logic [LANES-1:0] accepted
);

	logic [7:0] cnt_q   [LANES];
	logic [7:0] cnt_nxt [LANES];

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			accepted[j] = 1'b0;
			cnt_nxt[j]  = 8'd0;
			if (touch[j]) begin
				cnt_nxt[j] = cnt_q[j];
				if (cnt_q[j] < debounce_count) begin
					cnt_nxt[j]  = cnt_q[j] + 8'd1;
					accepted[j] = (cnt_q[j] + 8'd1) == debounce_count;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LANES; j++) cnt_q[j] <= 8'd0;
		end else if (tick_en) begin
			for (int j = 0; j < LANES; j++) cnt_q[j] <= cnt_nxt[j];
		end
	end

endmodule

// ----- hdl/touch_key_debounce_backlight_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// touch_key_debounce_backlight_top
// Debounces touch channels, drives key and display backlights with hold
// timers, beeps on accepted keys and latches one key for the host to read.
// -----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | beat contents
//  ---------+-----+------------------+------------------------------------------
//  sample   | in  | valid / ready    | mode, touch_vector, display_time
//  result   | out | valid / ready    | key_valid, key_channel, accepted_mask,
//           |     |                  | beep, display_on, key_led_mask,
//           |     |                  | display_time_left
//  cfg      | in  | cfg_wr_en only   | cfg_index, cfg_wdata (no read-back)
//
//  One beat per cycle while result is not stalled; an accepted beat passes
//  through the input register and then the result register onto result.
//  All channels are evaluated in parallel by the scan logic.
//  Reset clears control state and loads the timers and registers with their
//  defaults; no clearing pass is needed. A stall on result holds the result
//  register and the input register; sample stays ready while either is free.
//
module touch_key_debounce_backlight_top #(
	parameter int CHANNELS = tkdb_pkg::CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tkdb_in_if.sink                          sample,
	tkdb_out_if.source                       result,
	input  logic                             cfg_wr_en,
	input  logic [tkdb_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [tkdb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	// Only the low touch bits can ever be pressed; channels above stay idle.
	localparam int LANES = (CHANNELS < tkdb_pkg::TOUCH_W) ? CHANNELS : tkdb_pkg::TOUCH_W;
	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

	// configuration registers
	logic [7:0]  debounce_q;
	logic [15:0] disp_hold_q;
	logic [15:0] light_hold_q;

	// input stage
	logic               valid_s1;
	tkdb_pkg::in_beat_t beat_s1;

	// block state
	logic             pend_valid_q;
	logic [IDX_W-1:0] pend_key_q;
	logic [15:0]      disp_timer_q;
	logic [15:0]      light_timer_q;
	logic             disp_lit_q;
	logic [LANES-1:0] lit_keys_q;

	// result register
	logic                result_valid_q;
	tkdb_pkg::out_beat_t result_q;

	logic advance;
	logic tick_en;

	// scan results and next-state values
	logic [LANES-1:0] touch_s1;
	logic [LANES-1:0] accepted;
	logic [LANES-1:0] lower_pressed;
	logic [LANES-1:0] wake;
	logic [LANES-1:0] low_mask;
	logic             any_press;
	logic             any_acc;
	logic [IDX_W-1:0] hi_idx;
	logic             hi_wake;
	logic [15:0]      disp_reload;
	logic [15:0]      light_reload;

	logic             pend_valid_nxt;
	logic [IDX_W-1:0] pend_key_nxt;
	logic [15:0]      disp_timer_nxt;
	logic [15:0]      light_timer_nxt;
	logic             disp_lit_nxt;
	logic [LANES-1:0] lit_keys_nxt;
	tkdb_pkg::out_beat_t result_nxt;

	// Move the input register whenever the result register can take its beat.
	assign advance      = !result_valid_q || result.ready;
	assign sample.ready = !valid_s1 || advance;
	assign tick_en      = valid_s1 && advance && (beat_s1.mode == tkdb_pkg::MODE_TICK);
	assign touch_s1     = beat_s1.touch_vector[LANES-1:0];

	assign result.valid = result_valid_q;
	assign result.beat  = result_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= tkdb_pkg::DEBOUNCE_RST;
			disp_hold_q  <= tkdb_pkg::DISP_HOLD_RST;
			light_hold_q <= tkdb_pkg::LIGHT_HOLD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tkdb_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_wdata[7:0];
				tkdb_pkg::REG_DISP_HOLD:  disp_hold_q  <= cfg_wdata;
				tkdb_pkg::REG_LIGHT_HOLD: light_hold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tkdb_scan #(
		.LANES (LANES)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick_en        (tick_en),
		.touch          (touch_s1),
		.debounce_count (debounce_q),
		.accepted       (accepted)
	);

	// A channel sees the display timer as reloaded once any lower channel
	// is pressed, otherwise as it stood at the start of the tick.
	always_comb begin
		hi_idx  = '0;
		hi_wake = 1'b0;
		for (int j = 0; j < LANES; j++) begin
			low_mask         = (LANES'(1) << j) - LANES'(1);
			lower_pressed[j] = |(touch_s1 & low_mask);
			wake[j]          = accepted[j] &&
				(lower_pressed[j] ? (disp_hold_q == 16'd0) : (disp_timer_q == 16'd0));
		end
		// highest accepted channel decides the pending key
		for (int j = 0; j < LANES; j++) begin
			if (accepted[j]) begin
				hi_idx  = IDX_W'(j);
				hi_wake = wake[j];
			end
		end
	end

	assign any_press    = |touch_s1;
	assign any_acc      = |accepted;
	assign disp_reload  = any_press ? disp_hold_q : disp_timer_q;
	assign light_reload = any_press ? light_hold_q : light_timer_q;

	always_comb begin
		pend_valid_nxt  = pend_valid_q;
		pend_key_nxt    = pend_key_q;
		disp_timer_nxt  = disp_timer_q;
		light_timer_nxt = light_timer_q;
		disp_lit_nxt    = disp_lit_q;
		lit_keys_nxt    = lit_keys_q;
		result_nxt      = '0;

		case (beat_s1.mode)
			tkdb_pkg::MODE_TICK: begin
				if (any_acc) begin
					pend_valid_nxt = !hi_wake;
					pend_key_nxt   = hi_wake ? '0 : hi_idx;
				end
				// count down, drop the lights of an expired timer
				if (disp_reload != 16'd0) begin
					disp_timer_nxt = disp_reload - 16'd1;
					disp_lit_nxt   = disp_lit_q || (|wake);
				end else begin
					disp_timer_nxt = 16'd0;
					disp_lit_nxt   = 1'b0;
				end
				if (light_reload != 16'd0) begin
					light_timer_nxt = light_reload - 16'd1;
					lit_keys_nxt    = lit_keys_q | accepted;
				end else begin
					light_timer_nxt = 16'd0;
					lit_keys_nxt    = '0;
				end
				result_nxt.accepted_mask = tkdb_pkg::TOUCH_W'(accepted);
				result_nxt.beep          = any_acc;
			end
			tkdb_pkg::MODE_READ: begin
				result_nxt.key_valid   = pend_valid_q;
				result_nxt.key_channel = pend_valid_q ? 4'(pend_key_q) : 4'd0;
				pend_valid_nxt         = 1'b0;
				pend_key_nxt           = '0;
			end
			tkdb_pkg::MODE_SET_DISP: begin
				disp_timer_nxt = beat_s1.display_time;
				disp_lit_nxt   = 1'b1;
			end
			default: ;
		endcase

		result_nxt.display_on        = disp_lit_nxt;
		result_nxt.key_led_mask      = tkdb_pkg::TOUCH_W'(lit_keys_nxt);
		result_nxt.display_time_left = disp_timer_nxt;
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			beat_s1 <= sample.beat;
		end
	end

	// state and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q   <= 1'b0;
			pend_key_q     <= '0;
			disp_timer_q   <= tkdb_pkg::DISP_TIMER_RST;
			light_timer_q  <= tkdb_pkg::LIGHT_HOLD_RST;
			disp_lit_q     <= 1'b0;
			lit_keys_q     <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				pend_valid_q  <= pend_valid_nxt;
				pend_key_q    <= pend_key_nxt;
				disp_timer_q  <= disp_timer_nxt;
				light_timer_q <= light_timer_nxt;
				disp_lit_q    <= disp_lit_nxt;
				lit_keys_q    <= lit_keys_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_nxt;
		end
	end

endmodule

// ----- sim/touch_key_debounce_backlight_top_test.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// touch_key_debounce_backlight_top_test
// Self-checking bench for the touch key debounce and backlight block. A
// clocked driver feeds sample beats from a queue, and a scan predictor
// computes the panel status for each accepted beat. A clocked monitor checks
// every result beat field by field against the oldest predicted status. Both
// sides idle at random, and the receiver stalls once for a long stretch.
// -----------------------------------------------------------------------------
module touch_key_debounce_backlight_top_test;

	// mode three has no name in the package; the block ignores it
	localparam logic [1:0]  MODE_UNUSED     = 2'd3;
	localparam int unsigned PRESSURE_CYCLES = 400;
	localparam int unsigned WATCHDOG_LIMIT  = 2000;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [tkdb_pkg::REG_IDX_W-1:0]  cfg_index;
	logic [tkdb_pkg::CFG_DATA_W-1:0] cfg_wdata;

	tkdb_in_if  sample_ch ();
	tkdb_out_if result_ch ();

	touch_key_debounce_backlight_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Sample beats waiting for the driver, and the panel status predicted for
	// every accepted beat, oldest first.
	tkdb_pkg::in_beat_t  touch_beats[$];
	tkdb_pkg::out_beat_t panel_status_q[$];

	int unsigned beats_queued;
	int unsigned status_seen;
	int unsigned mismatch_count;
	int unsigned source_gap;
	int unsigned sink_hold;
	int unsigned quiet_cycles;
	logic        pressure_done;
	logic        steady_flow;

	// Predictor copy of the registers and of the scan state.
	logic [7:0]  debounce_reg;
	logic [15:0] disp_hold_reg;
	logic [15:0] light_hold_reg;
	logic [7:0]  press_cnt [tkdb_pkg::CHANNELS_DEF];
	logic        pend_valid;
	logic [3:0]  pend_ch;
	logic [15:0] disp_timer;
	logic [15:0] light_timer;
	logic        disp_lit;
	logic [15:0] lit_keys;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Load the predictor with the state the block comes out of reset with.
	task automatic reset_scan_model();
		debounce_reg   = tkdb_pkg::DEBOUNCE_RST;
		disp_hold_reg  = tkdb_pkg::DISP_HOLD_RST;
		light_hold_reg = tkdb_pkg::LIGHT_HOLD_RST;
		for (int j = 0; j < tkdb_pkg::CHANNELS_DEF; j++)
			press_cnt[j] = 8'd0;
		pend_valid  = 1'b0;
		pend_ch     = 4'd0;
		disp_timer  = tkdb_pkg::DISP_TIMER_RST;
		light_timer = tkdb_pkg::LIGHT_HOLD_RST;
		disp_lit    = 1'b0;
		lit_keys    = 16'd0;
	endtask

	// Advance the predicted panel by one sample beat and return its status.
	// Channels are scanned in ascending order: a lower channel that is pressed
	// reloads the display timer before a higher channel is judged, so a wake
	// press only happens while the timer, after any such reload, is zero.
	function automatic tkdb_pkg::out_beat_t scan_panel(tkdb_pkg::in_beat_t b);
		tkdb_pkg::out_beat_t r;
		logic [15:0]         acc;
		r   = '0;
		acc = 16'd0;
		case (b.mode)
			tkdb_pkg::MODE_TICK: begin
				for (int j = 0; j < tkdb_pkg::CHANNELS_DEF; j++) begin
					if (b.touch_vector[j]) begin
						if (press_cnt[j] < debounce_reg) begin
							press_cnt[j] = press_cnt[j] + 8'd1;
							if (press_cnt[j] == debounce_reg) begin
								acc[j]      = 1'b1;
								lit_keys[j] = 1'b1;
								if (disp_timer == 16'd0) begin
									// wake press: light the display, drop the key
									pend_valid = 1'b0;
									pend_ch    = 4'd0;
									disp_lit   = 1'b1;
								end else begin
									pend_valid = 1'b1;
									pend_ch    = 4'(j);
								end
							end
						end
						light_timer = light_hold_reg;
						disp_timer  = disp_hold_reg;
					end else begin
						press_cnt[j] = 8'd0;
					end
				end
				// count the hold timers down; a timer already at zero drops its lights
				if (disp_timer != 16'd0)
					disp_timer = disp_timer - 16'd1;
				else
					disp_lit = 1'b0;
				if (light_timer != 16'd0)
					light_timer = light_timer - 16'd1;
				else
					lit_keys = 16'd0;
				r.accepted_mask = acc;
				r.beep          = |acc;
			end
			tkdb_pkg::MODE_READ: begin
				if (pend_valid) begin
					r.key_valid   = 1'b1;
					r.key_channel = pend_ch;
				end
				pend_valid = 1'b0;
				pend_ch    = 4'd0;
			end
			tkdb_pkg::MODE_SET_DISP: begin
				disp_timer = b.display_time;
				disp_lit   = 1'b1;
			end
			default: begin
				// ignored beat: status reported unchanged
			end
		endcase
		r.display_on        = disp_lit;
		r.key_led_mask      = lit_keys;
		r.display_time_left = disp_timer;
		return r;
	endfunction

	function automatic void queue_beat(logic [1:0] mode, logic [15:0] touch,
		logic [15:0] dtime);
		tkdb_pkg::in_beat_t b;
		b.mode         = mode;
		b.touch_vector = touch;
		b.display_time = dtime;
		touch_beats.push_back(b);
		beats_queued++;
	endfunction

	// Idle length before the next beat: mostly none or short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at result %0d: %s", status_seen, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic check_status(tkdb_pkg::out_beat_t got);
		tkdb_pkg::out_beat_t want;
		if (panel_status_q.size() == 0) begin
			report_mismatch($sformatf("result beat %h with nothing predicted", got));
		end else begin
			want = panel_status_q.pop_front();
			compare_field("key_valid", 16'(got.key_valid), 16'(want.key_valid));
			compare_field("key_channel", 16'(got.key_channel), 16'(want.key_channel));
			compare_field("accepted_mask", got.accepted_mask, want.accepted_mask);
			compare_field("beep", 16'(got.beep), 16'(want.beep));
			compare_field("display_on", 16'(got.display_on), 16'(want.display_on));
			compare_field("key_led_mask", got.key_led_mask, want.key_led_mask);
			compare_field("display_time_left", got.display_time_left,
				want.display_time_left);
		end
	endtask

	// Hold until nothing is queued, offered or predicted. Sample at the falling
	// edge so the clocked blocks have settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (touch_beats.size() != 0 || sample_ch.valid || panel_status_q.size() != 0);
	endtask

	task automatic write_reg(logic [tkdb_pkg::REG_IDX_W-1:0] idx,
		logic [tkdb_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			tkdb_pkg::REG_DEBOUNCE:   debounce_reg   = value[7:0];
			tkdb_pkg::REG_DISP_HOLD:  disp_hold_reg  = value;
			tkdb_pkg::REG_LIGHT_HOLD: light_hold_reg = value;
			default: ;
		endcase
	endtask

	// Write all three registers once the block has drained. Every beat yields
	// a result, so an empty prediction queue means the block is idle.
	task automatic apply_settings(logic [7:0] deb, logic [15:0] dhold,
		logic [15:0] lhold);
		wait_idle();
		write_reg(tkdb_pkg::REG_DEBOUNCE, {8'd0, deb});
		write_reg(tkdb_pkg::REG_DISP_HOLD, dhold);
		write_reg(tkdb_pkg::REG_LIGHT_HOLD, lhold);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random traffic: mostly press runs held long enough to cross the debounce
	// count (some cut short, some with a bouncing bit), mixed with reads,
	// display time writes, noise ticks and ignored beats.
	task automatic queue_random_traffic(int unsigned target);
		int unsigned stop_at;
		int unsigned run_len;
		int unsigned bounce_at;
		logic [15:0] keys;
		logic [15:0] touch;
		stop_at = beats_queued + target;
		while (beats_queued < stop_at) begin
			case ($urandom_range(0, 11))
				0: queue_beat(tkdb_pkg::MODE_SET_DISP, 16'($urandom),
					($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom));
				1: queue_beat(tkdb_pkg::MODE_TICK, 16'($urandom), 16'($urandom));
				2: queue_beat(tkdb_pkg::MODE_READ, 16'($urandom), 16'($urandom));
				3: queue_beat(MODE_UNUSED, 16'($urandom), 16'($urandom));
				default: begin
					case ($urandom_range(0, 2))
						0: keys = 16'd1 << $urandom_range(0, 15);
						1: keys = 16'($urandom & $urandom & $urandom);
						default: keys = 16'($urandom);
					endcase
					run_len = debounce_reg + $urandom_range(0, 2);
					if ($urandom_range(0, 4) == 0 && run_len > 1)
						run_len = run_len - 2;
					bounce_at = $urandom_range(0, 2 * run_len);
					for (int i = 0; i < run_len; i++) begin
						touch = keys;
						if (i == bounce_at)
							touch = keys ^ (16'd1 << $urandom_range(0, 15));
						queue_beat(tkdb_pkg::MODE_TICK, touch, 16'($urandom));
						if ($urandom_range(0, 9) == 0)
							queue_beat(tkdb_pkg::MODE_READ, 16'($urandom), 16'($urandom));
					end
					// release fully or drop only part of the held keys
					queue_beat(tkdb_pkg::MODE_TICK,
						($urandom_range(0, 1) != 0) ? 16'd0 : (keys & 16'($urandom)),
						16'($urandom));
					if ($urandom_range(0, 3) != 0)
						queue_beat(tkdb_pkg::MODE_READ, 16'($urandom), 16'($urandom));
				end
			endcase
		end
	endtask

	task automatic run_phase(logic [7:0] deb, logic [15:0] dhold, logic [15:0] lhold,
		int unsigned target);
		apply_settings(deb, dhold, lhold);
		steady_flow = ($urandom_range(0, 3) == 0);
		queue_random_traffic(target);
	endtask

	// Driver: advance to the next queued beat once the current one is taken,
	// after an optional gap. Predict the status at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.beat  <= '0;
			source_gap      <= 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready)
				panel_status_q.push_back(scan_panel(sample_ch.beat));
			if (!sample_ch.valid || sample_ch.ready) begin
				if (source_gap != 0) begin
					sample_ch.valid <= 1'b0;
					source_gap      <= source_gap - 1;
				end else if (touch_beats.size() != 0) begin
					sample_ch.beat  <= touch_beats.pop_front();
					sample_ch.valid <= 1'b1;
					source_gap      <= pick_gap();
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat, then drive ready. Once, with plenty of
	// beats still queued, hold ready low long enough for the block to fill up
	// and push back on the sample channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			sink_hold       <= 0;
			pressure_done   <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				status_seen++;
				check_status(result_ch.beat);
			end
			if (sink_hold != 0) begin
				result_ch.ready <= 1'b0;
				sink_hold       <= sink_hold - 1;
			end else if (!pressure_done && status_seen >= 100 && touch_beats.size() > 8) begin
				result_ch.ready <= 1'b0;
				sink_hold       <= PRESSURE_CYCLES;
				pressure_done   <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
				sink_hold       <= pick_gap();
			end
		end
	end

	// Watchdog: drop the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
				(result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		beats_queued    = 0;
		steady_flow     = 1'b0;
		reset_scan_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: all keys accepted together (highest one latched),
		// read with and without a pending key, an ignored beat with every bit
		// set, display time at both extremes, and the display timing out.
		queue_beat(tkdb_pkg::MODE_TICK, 16'h0000, 16'h0000);
		repeat (5) queue_beat(tkdb_pkg::MODE_TICK, 16'hFFFF, 16'h0000);
		queue_beat(tkdb_pkg::MODE_READ, 16'h0000, 16'h0000);
		queue_beat(tkdb_pkg::MODE_READ, 16'hFFFF, 16'hFFFF);
		queue_beat(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
		queue_beat(tkdb_pkg::MODE_SET_DISP, 16'h0000, 16'hFFFF);
		queue_beat(tkdb_pkg::MODE_SET_DISP, 16'hFFFF, 16'h0000);
		queue_beat(tkdb_pkg::MODE_TICK, 16'h0000, 16'hFFFF);

		// Zero hold times with single-tick debounce: a key latched while the
		// display is lit, then two wake presses in one tick that clear it.
		apply_settings(8'd1, 16'd0, 16'd0);
		queue_beat(tkdb_pkg::MODE_SET_DISP, 16'h0000, 16'd5);
		queue_beat(tkdb_pkg::MODE_TICK, 16'h0004, 16'h0000);
		queue_beat(tkdb_pkg::MODE_TICK, 16'h0000, 16'h0000);
		queue_beat(tkdb_pkg::MODE_TICK, 16'h8001, 16'h0000);
		queue_beat(tkdb_pkg::MODE_READ, 16'h0000, 16'h0000);

		// A lower channel still debouncing reloads the display timer, so a
		// higher channel accepted in the same tick latches its key.
		apply_settings(8'd2, 16'd10, 16'd10);
		queue_beat(tkdb_pkg::MODE_TICK, 16'h0020, 16'h0000);
		queue_beat(tkdb_pkg::MODE_SET_DISP, 16'h0000, 16'h0000);
		queue_beat(tkdb_pkg::MODE_TICK, 16'h0021, 16'h0000);
		queue_beat(tkdb_pkg::MODE_READ, 16'h0000, 16'h0000);

		// Zero debounce count: holding every key never accepts one.
		apply_settings(8'd0, 16'hFFFF, 16'd0);
		repeat (2) queue_beat(tkdb_pkg::MODE_TICK, 16'hFFFF, 16'h0000);
		queue_beat(tkdb_pkg::MODE_TICK, 16'h0000, 16'h0000);

		// Random phases over several settings, short holds so the lights go out
		// and wake presses occur, ending on the widest debounce and hold values.
		run_phase(8'd3, 16'd10, 16'd6, 40);
		run_phase(8'd1, 16'd0, 16'd0, 30);
		run_phase(8'd2, 16'd4, 16'hFFFF, 40);
		run_phase(8'd5, 16'hFFFF, 16'd3, 40);
		run_phase(8'd1, 16'd2, 16'd2, 40);
		run_phase(8'($urandom_range(1, 8)), 16'($urandom_range(0, 30)),
			16'($urandom_range(0, 30)), 30);
		run_phase(8'd255, 16'hFFFF, 16'hFFFF, 10);

		// Drain, then let the pipeline settle before the verdict.
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
